// ===== hw/rtl/sof_length_field_deframer_defines.svh =====
// Assertion macros shared by the deframer checker.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef SOF_LENGTH_FIELD_DEFRAMER_DEFINES_SVH
`define SOF_LENGTH_FIELD_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sfd_pkg.sv =====
// Shared types, constants and helpers for the length-prefixed deframer.
// No dependencies.
package sfd_pkg;

	localparam int LENGTH_BITS = 10;  // decoded length width, 8..16
	localparam int FIELD_W     = 10;  // reported offset/length width
	localparam int CNT_W       = 32;
	localparam logic [7:0] MARKER_RESET = 8'h55;

	typedef enum logic [1:0] {
		KIND_DISCARD = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_LAST    = 2'd2,
		KIND_HDR_ERR = 2'd3
	} kind_t;

	typedef logic [LENGTH_BITS-1:0] len_t;

	// Per-byte result fields held in the output register
	typedef struct packed {
		logic [7:0]         data;
		kind_t              kind;
		logic [FIELD_W-1:0] offset;
		logic [FIELD_W-1:0] length;
	} res_t;

	// Counter snapshot reported with each result
	typedef struct packed {
		logic [CNT_W-1:0] frames;
		logic [CNT_W-1:0] received;
		logic [CNT_W-1:0] framed;
		logic [CNT_W-1:0] discarded;
	} cnt_t;

	// Report a length-width value modulo 2**FIELD_W
	function automatic logic [FIELD_W-1:0] to_field(input len_t v);
		logic [15:0] w;
		w = 16'(v);
		return w[FIELD_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/sfd_in_stage.sv =====
// Input register of the deframer: captures one received byte per transfer.
// Depends on sfd_pkg (imported for project consistency).
module sfd_in_stage
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] rx_byte,
	output logic       in_stall,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// Hold while a byte waits and the parser cannot take it
	assign in_stall = valid_s1 && !adv;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== hw/rtl/sfd_parser.sv =====
// Frame parser: classifies the registered byte, updates framing state and
// counters, and loads the result register. Depends on sfd_pkg.
module sfd_parser
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] byte_s1,
	input  logic [7:0] marker,
	output res_t       res_s2,
	output cnt_t       cnt_q
);

	logic in_frame_q, in_frame_d;
	len_t pos_q, pos_d;
	logic [7:0] low_q, low_d;
	len_t len_q, len_d;
	logic [15:0] hdr_word;
	len_t hdr_len;
	logic [LENGTH_BITS:0] pos_inc;
	logic close;
	logic [1:0] disc_inc;
	kind_t kind;
	len_t off, len_o;
	cnt_t cnt_d;

	assign hdr_word = {byte_s1, low_q};
	assign hdr_len  = hdr_word[LENGTH_BITS-1:0];
	assign pos_inc  = {1'b0, pos_q} + (LENGTH_BITS+1)'(1);

	// Byte classification and next framing state
	always_comb begin
		kind       = KIND_DISCARD;
		off        = '0;
		len_o      = '0;
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		low_d      = low_q;
		len_d      = len_q;
		close      = 1'b0;
		disc_inc   = 2'd0;
		if (!in_frame_q) begin
			if (byte_s1 == marker) begin
				in_frame_d = 1'b1;
				pos_d      = LENGTH_BITS'(1);
				len_d      = '0;
				kind       = KIND_FRAME;
			end else begin
				disc_inc = 2'd1;
			end
		end else begin
			off = pos_q;
			if (pos_q == LENGTH_BITS'(1)) begin
				// length low byte
				low_d = byte_s1;
				pos_d = LENGTH_BITS'(2);
				kind  = KIND_FRAME;
			end else if (pos_q == LENGTH_BITS'(2)) begin
				// length high byte: validate the decoded length
				len_d = hdr_len;
				len_o = hdr_len;
				if (hdr_len < LENGTH_BITS'(3)) begin
					disc_inc   = 2'd3;
					in_frame_d = 1'b0;
					pos_d      = '0;
					kind       = KIND_HDR_ERR;
				end else if (hdr_len == LENGTH_BITS'(3)) begin
					kind  = KIND_LAST;
					close = 1'b1;
				end else begin
					kind  = KIND_FRAME;
					pos_d = LENGTH_BITS'(3);
				end
			end else begin
				// body and trailer
				len_o = len_q;
				if (pos_inc >= {1'b0, len_q}) begin
					kind  = KIND_LAST;
					close = 1'b1;
				end else begin
					kind  = KIND_FRAME;
					pos_d = pos_inc[LENGTH_BITS-1:0];
				end
			end
		end
		if (close) begin
			in_frame_d = 1'b0;
			pos_d      = '0;
		end
	end

	// Running counters, all wrap
	always_comb begin
		cnt_d.received  = cnt_q.received + CNT_W'(1);
		cnt_d.discarded = cnt_q.discarded + CNT_W'(disc_inc);
		cnt_d.frames    = cnt_q.frames + CNT_W'(close);
		cnt_d.framed    = cnt_q.framed + (close ? CNT_W'(len_d) : '0);
	end

	// Framing state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			low_q      <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
		end else if (adv) begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			low_q      <= low_d;
			len_q      <= len_d;
			cnt_q      <= cnt_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.data   <= byte_s1;
			res_s2.kind   <= kind;
			res_s2.offset <= to_field(off);
			res_s2.length <= to_field(len_o);
		end
	end

endmodule

// ===== hw/rtl/sof_length_field_deframer.sv =====
// Top level of the start-of-frame, length-prefixed byte deframer.
// Depends on sfd_pkg, sfd_in_stage and sfd_parser.
//
// Usage:
//   Input channel in_valid/in_stall carries rx_byte; a transfer happens when
//   in_valid is high and in_stall low. Output channel out_valid/out_stall
//   carries out_byte, byte_kind, frame_offset, frame_length and the four
//   running counters, each counter already including the byte shown.
//   start_marker is written through cfg_valid/cfg_ready (always ready); the
//   user must write it only while the block is idle, a rule the block itself
//   leaves unchecked; it resets to 0x55. An input transfer loads the input
//   register; the result register loads from it when adv is high, which an
//   output stall holds off, and out_valid rises as it loads. Throughput: one
//   byte per cycle while out_stall is low, set by the combinational
//   classify/counter update between the two registers.
//   Reset: hunting, all counters zero, both registers empty.
//   Stall: a stalled result holds; if the input register is empty, one more
//   byte is taken into it, and in_stall then rises until the result drains.
module sof_length_field_deframer
	import sfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        start_marker,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic [1:0]        byte_kind,
	output logic [FIELD_W-1:0] frame_offset,
	output logic [FIELD_W-1:0] frame_length,
	output logic [CNT_W-1:0]  frames_done,
	output logic [CNT_W-1:0]  bytes_received,
	output logic [CNT_W-1:0]  bytes_framed,
	output logic [CNT_W-1:0]  bytes_discarded
);

	logic [7:0] marker_q;
	logic       out_valid_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	res_t       res_s2;
	cnt_t       cnt_q;

	// Marker register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			marker_q <= start_marker;
		end
	end

	// Advance when a byte waits and the result register is free or draining
	assign adv = valid_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	sfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.in_stall (in_stall),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.marker  (marker_q),
		.res_s2  (res_s2),
		.cnt_q   (cnt_q)
	);

	// Output ports
	assign out_valid       = out_valid_q;
	assign out_byte        = res_s2.data;
	assign byte_kind       = res_s2.kind;
	assign frame_offset    = res_s2.offset;
	assign frame_length    = res_s2.length;
	assign frames_done     = cnt_q.frames;
	assign bytes_received  = cnt_q.received;
	assign bytes_framed    = cnt_q.framed;
	assign bytes_discarded = cnt_q.discarded;

endmodule

// ===== hw/rtl/sfd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
// Depends on sfd_pkg and sof_length_field_deframer_defines.svh.
`include "sof_length_field_deframer_defines.svh"

module sfd_checker
	import sfd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [7:0]         out_byte,
	input logic [1:0]         byte_kind,
	input logic [FIELD_W-1:0] frame_offset,
	input logic [FIELD_W-1:0] frame_length,
	input logic [CNT_W-1:0]   bytes_received
);

	// A stalled result holds
	`SFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(byte_kind) && $stable(bytes_received), "stalled result changed")

	// Discarded bytes carry no frame position or length
	`SFD_ASSERT_NOW(a_discard_zero, out_valid && byte_kind == KIND_DISCARD, frame_offset == '0 && frame_length == '0, "discarded byte has offset or length")

	// Header errors sit at offset 2 with a short length
	`SFD_ASSERT_NOW(a_hdr_err, out_valid && byte_kind == KIND_HDR_ERR, frame_offset == FIELD_W'(2) && frame_length < FIELD_W'(3), "bad header error report")

	// The last byte sits exactly at length - 1
	`SFD_ASSERT_NOW(a_last_pos, out_valid && byte_kind == KIND_LAST, FIELD_W'(frame_offset + FIELD_W'(1)) == frame_length, "last byte not at length - 1")

endmodule

bind sof_length_field_deframer sfd_checker u_sfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.out_byte       (out_byte),
	.byte_kind      (byte_kind),
	.frame_offset   (frame_offset),
	.frame_length   (frame_length),
	.bytes_received (bytes_received)
);

// ===== tb/sv/tb_sfd_scoreboard_pkg.sv =====
// Scoreboard for the length-prefixed deframer bench: byte classifier and result check.
// Depends on sfd_pkg for the kind codes, field widths and result structs.
`timescale 1ns / 100ps

package tb_sfd_scoreboard_pkg;
	import sfd_pkg::*;

	// One reported byte: tag fields plus the counter snapshot
	typedef struct packed {
		res_t r;
		cnt_t c;
	} byte_report_t;

	class sfd_byte_scoreboard;
		logic [7:0]       marker;
		bit               in_frame;
		len_t             next_pos;
		len_t             cur_len;
		logic [7:0]       len_low;
		logic [CNT_W-1:0] n_frames;
		logic [CNT_W-1:0] n_received;
		logic [CNT_W-1:0] n_framed;
		logic [CNT_W-1:0] n_discarded;
		byte_report_t     expected_reports[$];
		int               errors;
		int               reports_checked;
		int               kind_count[4];

		function new();
			marker = MARKER_RESET;
			in_frame = 1'b0;
			next_pos = '0;
			cur_len = '0;
			len_low = '0;
			n_frames = '0;
			n_received = '0;
			n_framed = '0;
			n_discarded = '0;
			errors = 0;
			reports_checked = 0;
			foreach (kind_count[k]) kind_count[k] = 0;
		endfunction

		function void set_marker(logic [7:0] v);
			marker = v;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void close_frame();
			n_frames += 1;
			n_framed += CNT_W'(cur_len);
			in_frame = 1'b0;
			next_pos = '0;
		endfunction

		// Classify one transferred byte and queue the report it must produce
		function void take_byte(logic [7:0] b);
			byte_report_t e;
			len_t         off;
			len_t         len;
			e = '0;
			off = '0;
			len = '0;
			n_received += 1;
			e.r.kind = KIND_DISCARD;
			if (!in_frame) begin
				if (b == marker) begin
					in_frame = 1'b1;
					next_pos = len_t'(1);
					cur_len = '0;
					e.r.kind = KIND_FRAME;
				end else begin
					n_discarded += 1;
				end
			end else begin
				off = next_pos;
				if (off == len_t'(1)) begin
					// low length byte
					len_low = b;
					e.r.kind = KIND_FRAME;
					next_pos = len_t'(2);
				end else if (off == len_t'(2)) begin
					// high length byte completes the header
					cur_len = len_t'({b, len_low});
					len = cur_len;
					if (cur_len < len_t'(3)) begin
						n_discarded += 3;
						in_frame = 1'b0;
						next_pos = '0;
						e.r.kind = KIND_HDR_ERR;
					end else if (cur_len == len_t'(3)) begin
						e.r.kind = KIND_LAST;
						close_frame();
					end else begin
						e.r.kind = KIND_FRAME;
						next_pos = len_t'(3);
					end
				end else begin
					len = cur_len;
					if (32'(off) + 32'd1 >= 32'(cur_len)) begin
						e.r.kind = KIND_LAST;
						close_frame();
					end else begin
						e.r.kind = KIND_FRAME;
						next_pos = off + len_t'(1);
					end
				end
			end
			e.r.data = b;
			e.r.offset = FIELD_W'(off);
			e.r.length = FIELD_W'(len);
			e.c.frames = n_frames;
			e.c.received = n_received;
			e.c.framed = n_framed;
			e.c.discarded = n_discarded;
			expected_reports.push_back(e);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
						$realtime, name, reports_checked, want, seen);
			end
		endfunction

		// Compare one output transfer against the oldest queued report
		function void check_report(byte_report_t got);
			byte_report_t e;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with nothing pending, out_byte 0x%0h",
						$realtime, got.r.data);
				return;
			end
			e = expected_reports[0];
			expected_reports.delete(0);
			reports_checked++;
			kind_count[int'(e.r.kind)]++;
			check_field("out_byte", 32'(e.r.data), 32'(got.r.data));
			check_field("byte_kind", 32'(e.r.kind), 32'(got.r.kind));
			check_field("frame_offset", 32'(e.r.offset), 32'(got.r.offset));
			check_field("frame_length", 32'(e.r.length), 32'(got.r.length));
			check_field("frames_done", e.c.frames, got.c.frames);
			check_field("bytes_received", e.c.received, got.c.received);
			check_field("bytes_framed", e.c.framed, got.c.framed);
			check_field("bytes_discarded", e.c.discarded, got.c.discarded);
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_sof_length_field_deframer.sv =====
// Top-level bench for sof_length_field_deframer: drives bytes and marker writes, checks results.
// Depends on sfd_pkg, tb_sfd_scoreboard_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb_sof_length_field_deframer;
	import sfd_pkg::*;
	import tb_sfd_scoreboard_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 64;
	localparam int MAX_WAIT       = 11;
	localparam int N_DIRECTED     = 23;

	// Hunting extremes, length 3, short lengths, masked high bits, marker inside a frame
	localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
		8'h00, 8'hFF,
		8'h55, 8'h03, 8'h00,
		8'h55, 8'h00, 8'h00,
		8'h55, 8'h02, 8'h00,
		8'h55, 8'h01, 8'h04,
		8'h55, 8'h05, 8'h00, 8'h55, 8'hAA,
		8'h55, 8'h04, 8'hFC, 8'h11
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         start_marker = 8'h00;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_byte;
	logic [1:0]         byte_kind;
	logic [FIELD_W-1:0] frame_offset;
	logic [FIELD_W-1:0] frame_length;
	logic [CNT_W-1:0]   frames_done;
	logic [CNT_W-1:0]   bytes_received;
	logic [CNT_W-1:0]   bytes_framed;
	logic [CNT_W-1:0]   bytes_discarded;

	sfd_byte_scoreboard sb = new();

	bit         tx_no_idle = 1'b0;
	bit         rx_no_idle = 1'b0;
	bit         rx_hold_req = 1'b0;
	logic [7:0] cur_marker = MARKER_RESET;
	logic [7:0] rand_marker = 8'h00;
	int         bytes_sent = 0;
	int         idle_cycles = 0;
	int         in_stall_cycles = 0;

	always #CLK_HALF clk = ~clk;

	sof_length_field_deframer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.start_marker    (start_marker),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.byte_kind       (byte_kind),
		.frame_offset    (frame_offset),
		.frame_length    (frame_length),
		.frames_done     (frames_done),
		.bytes_received  (bytes_received),
		.bytes_framed    (bytes_framed),
		.bytes_discarded (bytes_discarded)
	);

	function automatic int draw_wait(bit no_idle);
		return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// Sample transfers on all three channels
	always @(posedge clk) begin : sample_transfers
		byte_report_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.r.data = out_byte;
				got.r.kind = kind_t'(byte_kind);
				got.r.offset = frame_offset;
				got.r.length = frame_length;
				got.c.frames = frames_done;
				got.c.received = bytes_received;
				got.c.framed = bytes_framed;
				got.c.discarded = bytes_discarded;
				sb.check_report(got);
			end
			if (in_valid && !in_stall)
				sb.take_byte(rx_byte);
			if (cfg_valid && cfg_ready)
				sb.set_marker(start_marker);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && in_valid && in_stall)
			in_stall_cycles <= in_stall_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results pending",
				idle_cycles, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall before each result, one long hold-off on request
	initial begin : result_sink
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				n = HOLD_CYCLES;
			end else begin
				n = draw_wait(rx_no_idle);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Offer one byte after a random gap and wait for its transfer
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_wait(tx_no_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Frame of the given length; junk in the unused high bits of the length
	task automatic send_frame(input logic [9:0] len);
		send_byte(cur_marker);
		send_byte(len[7:0]);
		send_byte({6'($urandom_range(0, 63)), len[9:8]});
		for (int i = 3; i < int'(len); i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// Mostly frames of short lengths, some header errors and line noise
	task automatic run_random(input int n_bytes);
		int         stop_at;
		int         r;
		logic [9:0] len;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				r = $urandom_range(0, 99);
				len = (r < 10) ? 10'($urandom_range(0, 2)) :
					(r < 15) ? 10'($urandom_range(100, 300)) :
					10'($urandom_range(3, 24));
				send_frame(len);
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Stop offering until every queued result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_marker(input logic [7:0] v);
		cfg_valid <= 1'b1;
		start_marker <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_marker = v;
		@(negedge clk);
	endtask

	initial begin : main_seq
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
		drain_results();

		// reset marker, with a long receiver hold-off while bytes keep coming
		run_random(80);
		rx_hold_req = 1'b1;
		tx_no_idle = 1'b1;
		run_random(40);
		tx_no_idle = 1'b0;
		run_random(40);
		drain_results();

		// lowest marker, no idling on either side
		write_marker(8'h00);
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		run_random(90);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		drain_results();

		// highest marker
		write_marker(8'hFF);
		run_random(90);
		drain_results();

		rand_marker = 8'($urandom_range(0, 255));
		write_marker(rand_marker);
		tx_no_idle = 1'b1;
		run_random(90);
		tx_no_idle = 1'b0;
		drain_results();

		write_marker(MARKER_RESET);
		run_random(80);
		drain_results();
		repeat (10) @(negedge clk);

		$display("Run: %0d bytes checked (%0d frame, %0d last, %0d header error, %0d discarded)",
			sb.reports_checked, sb.kind_count[int'(KIND_FRAME)], sb.kind_count[int'(KIND_LAST)],
			sb.kind_count[int'(KIND_HDR_ERR)], sb.kind_count[int'(KIND_DISCARD)]);
		$display("Markers 0x55, 0x00, 0xFF, 0x%02h; input stalled %0d cycles; %0d errors",
			rand_marker, in_stall_cycles, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_in_stage.sv
hw/rtl/sfd_parser.sv
hw/rtl/sof_length_field_deframer.sv
hw/rtl/sfd_checker.sv
tb/sv/tb_sfd_scoreboard_pkg.sv
tb/sv/tb_sof_length_field_deframer.sv
